// ===== design/fifo_queue_with_key_search_macros.svh =====
// assertion macros for the queue with key search
// used by the datapath, no other dependencies
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define FQKS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fqks assertion failed");

// next-cycle implication under asynchronous active-low reset
`define FQKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fqks assertion failed");

`endif

// ===== design/fqks_pkg.sv =====
// shared types and constants for the queue with key search
// no dependencies
package fqks_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;

	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_UPDATE  = 2'd2,
		ACT_SEARCH  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] key;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] value_out;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DEQ,
		ST_SCAN,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    accept;
		logic    enq;
		logic    deq_rd;
		logic    deq_done;
		logic    scan_start;
		logic    scan;
		logic    upd_wr;
		logic    set_res;
		status_t res_status;
		logic    res_rd;
		logic    load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t action;
		logic    full;
		logic    empty;
		logic    rd_vld;
		logic    rd_last;
		logic    match;
		logic    out_free;
	} sts_t;

endpackage

// ===== design/fqks_ctrl.sv =====
// controller state machine for the queue with key search
// depends on fqks_pkg
module fqks_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fqks_pkg::sts_t sts,
	output fqks_pkg::cmd_t cmd
);

	fqks_pkg::state_t state_q;
	fqks_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqks_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqks_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = fqks_pkg::ST_DISPATCH;
				end
			end
			fqks_pkg::ST_DISPATCH: begin
				priority if (sts.action == fqks_pkg::ACT_ENQUEUE || sts.empty) begin
					state_d = fqks_pkg::ST_RESP;
				end else if (sts.action == fqks_pkg::ACT_DEQUEUE) begin
					state_d = fqks_pkg::ST_DEQ;
				end else begin
					state_d = fqks_pkg::ST_SCAN;
				end
			end
			fqks_pkg::ST_DEQ: begin
				if (sts.rd_vld) begin
					state_d = fqks_pkg::ST_RESP;
				end
			end
			fqks_pkg::ST_SCAN: begin
				if (sts.rd_vld && (sts.match || sts.rd_last)) begin
					state_d = fqks_pkg::ST_RESP;
				end
			end
			fqks_pkg::ST_RESP: begin
				if (sts.out_free) begin
					state_d = fqks_pkg::ST_IDLE;
				end
			end
			default: state_d = fqks_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.res_status = fqks_pkg::STS_OK;
		req_stall = (state_q != fqks_pkg::ST_IDLE);
		unique case (state_q)
			fqks_pkg::ST_IDLE: begin
				cmd.accept = req_valid;
			end
			fqks_pkg::ST_DISPATCH: begin
				priority if (sts.action == fqks_pkg::ACT_ENQUEUE) begin
					cmd.set_res = 1'b1;
					if (sts.full) begin
						cmd.res_status = fqks_pkg::STS_FULL;
					end else begin
						cmd.enq = 1'b1;
					end
				end else if (sts.empty) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = fqks_pkg::STS_EMPTY;
				end else if (sts.action == fqks_pkg::ACT_DEQUEUE) begin
					cmd.deq_rd = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			fqks_pkg::ST_DEQ: begin
				if (sts.rd_vld) begin
					cmd.deq_done = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_rd   = 1'b1;
				end
			end
			fqks_pkg::ST_SCAN: begin
				priority if (sts.rd_vld && sts.match) begin
					cmd.set_res = 1'b1;
					cmd.res_rd  = 1'b1;
					cmd.upd_wr  = (sts.action == fqks_pkg::ACT_UPDATE);
				end else if (sts.rd_vld && sts.rd_last) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = fqks_pkg::STS_NOT_FOUND;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			fqks_pkg::ST_RESP: begin
				cmd.load_out = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/fqks_dp.sv =====
// datapath for the queue with key search: entry memory, ring pointers,
// scan pointer, result and output registers; depends on fqks_pkg and the macros
`include "fifo_queue_with_key_search_macros.svh"

module fqks_dp #(
	parameter int QUEUE_DEPTH = fqks_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fqks_pkg::req_t req,
	input  fqks_pkg::cmd_t cmd,
	output fqks_pkg::sts_t sts,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fqks_pkg::rsp_t rsp
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
		logic [IW-1:0] nxt;
		nxt = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

	logic signed [31:0] mem [QUEUE_DEPTH];

	fqks_pkg::req_t     req_q;
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      pos_q;
	logic [CW-1:0]      issued_q;
	logic               rd_vld_q;
	logic               rd_last_q;
	logic signed [31:0] rdata_q;
	logic [IW-1:0]      rd_pos_q;
	fqks_pkg::status_t  res_status_q;
	logic signed [31:0] res_value_q;
	logic               rsp_valid_q;
	fqks_pkg::rsp_t     rsp_q;

	logic               full;
	logic               empty;
	logic               scan_issue;
	logic               scan_last;
	logic               rd_en;
	logic [IW-1:0]      raddr;
	logic               wr_en;
	logic [IW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [CW+4:0]      count_ext;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign scan_issue = cmd.scan && (issued_q != count_q);
	assign scan_last  = (issued_q == count_q - 1'b1);
	assign rd_en      = cmd.deq_rd || scan_issue;
	assign raddr      = cmd.deq_rd ? head_q : pos_q;
	assign wr_en      = cmd.enq || cmd.upd_wr;
	assign waddr      = cmd.enq ? tail_q : rd_pos_q;
	assign wdata      = cmd.enq ? req_q.key : req_q.new_value;
	assign count_ext  = {5'b0, count_q};

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q  <= mem[raddr];
			rd_pos_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rd_vld_q    <= 1'b0;
			rd_last_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			if (rd_en) begin
				rd_last_q <= cmd.deq_rd || scan_last;
			end
			if (cmd.enq) begin
				tail_q  <= ring_next(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.deq_done) begin
				head_q  <= ring_next(head_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, scan position and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.scan_start) begin
			pos_q    <= head_q;
			issued_q <= '0;
		end else if (scan_issue) begin
			pos_q    <= ring_next(pos_q);
			issued_q <= issued_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_rd ? rdata_q : 32'sd0;
		end
		if (cmd.load_out) begin
			rsp_q.status      <= res_status_q;
			rsp_q.value_out   <= res_value_q;
			rsp_q.entry_count <= count_ext[4:0];
		end
	end

	always_comb begin
		sts.action   = req_q.action;
		sts.full     = full;
		sts.empty    = empty;
		sts.rd_vld   = rd_vld_q;
		sts.rd_last  = rd_last_q;
		sts.match    = (rdata_q == req_q.key);
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FQKS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH))
	`FQKS_ASSERT_NOW(a_ptr_meet, clk, arst_n, empty || full, head_q == tail_q)
	`FQKS_ASSERT_NOW(a_no_enq_full, clk, arst_n, cmd.enq, !full)
	`FQKS_ASSERT_NEXT(a_deq_read, clk, arst_n, cmd.deq_rd, rd_vld_q && rd_pos_q == $past(head_q))

endmodule

// ===== design/fifo_queue_with_key_search.sv =====
// fifo_queue_with_key_search: ring-buffer queue of signed keys with search/update
// a request is registered on input transfer, then dispatched: enqueue, full or empty go
// straight to the result, dequeue reads the front entry, and search or update scans from
// the front, one entry read per cycle, until a hit or the rear; one request in flight, the
// next taken the cycle after its result loads; a stalled receiver holds the result back
// arst_n clears pointers, count and valids; entry memory is left undefined
module fifo_queue_with_key_search #(
	parameter int QUEUE_DEPTH = fqks_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fqks_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fqks_pkg::rsp_t rsp
);

	// command and status buses between controller and datapath
	fqks_pkg::cmd_t cmd;
	fqks_pkg::sts_t sts;

	// controller: sequences dispatch, dequeue read, scan and result transfer
	fqks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry memory, head/tail/count, scan compare, output register
	fqks_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== verif/tb_fifo_queue_with_key_search.sv =====
// self-checking testbench for fifo_queue_with_key_search: directed and random queue traffic
// predicts every result with its own ring model; needs fqks_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_fifo_queue_with_key_search;

	localparam int QDEPTH = fqks_pkg::QUEUE_DEPTH_DEFAULT;

	// receiver stall patterns, each kept for a random stretch of cycles
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	fqks_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	fqks_pkg::rsp_t rsp;

	// ring model of the queue, advanced once per accepted request
	logic signed [31:0] ring_store [QDEPTH];
	int unsigned        ring_head;
	int unsigned        ring_tail;
	int unsigned        ring_count;

	// results still owed by the block, oldest first
	fqks_pkg::rsp_t pending_rsp [$];

	int n_errors;
	int burst_left;
	int hold_off_cycles;

	fifo_queue_with_key_search #(
		.QUEUE_DEPTH(QDEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#(5_000_000);
		$display("tb_fifo_queue_with_key_search: done, errors");
		$finish;
	end

	// apply one request to the ring model and return the result it must produce
	function automatic fqks_pkg::rsp_t ring_apply(input fqks_pkg::req_t item);
		fqks_pkg::rsp_t res;
		int unsigned    pos;
		int unsigned    scanned;
		logic           hit;
		res.status    = fqks_pkg::STS_OK;
		res.value_out = '0;
		if (item.action == fqks_pkg::ACT_ENQUEUE) begin
			// a full queue refuses the key and stays as it is
			if (ring_count >= QDEPTH) begin
				res.status = fqks_pkg::STS_FULL;
			end else begin
				ring_store[ring_tail] = item.key;
				ring_tail = (ring_tail + 1) % QDEPTH;
				ring_count++;
			end
		end else if (ring_count == 0) begin
			// dequeue, search and update all answer empty on an empty queue
			res.status = fqks_pkg::STS_EMPTY;
		end else if (item.action == fqks_pkg::ACT_DEQUEUE) begin
			res.value_out = ring_store[ring_head];
			ring_head = (ring_head + 1) % QDEPTH;
			ring_count--;
		end else begin
			// front-to-rear scan, stops at the first match or at the rear
			res.status = fqks_pkg::STS_NOT_FOUND;
			pos = ring_head;
			scanned = 0;
			hit = 1'b0;
			while (!hit && scanned < ring_count) begin
				if (ring_store[pos] == item.key) begin
					hit = 1'b1;
					res.status = fqks_pkg::STS_OK;
					// the old value comes back, even for an update
					res.value_out = ring_store[pos];
					if (item.action == fqks_pkg::ACT_UPDATE)
						ring_store[pos] = item.new_value;
				end
				pos = (pos + 1) % QDEPTH;
				scanned++;
			end
		end
		res.entry_count = ring_count[4:0];
		return res;
	endfunction

	// one request transfer; the sender works in bursts with random gaps between them
	task automatic send_request(input fqks_pkg::action_t act,
			input logic signed [31:0] key_val, input logic signed [31:0] repl);
		fqks_pkg::req_t item;
		int             gap;
		item.action    = act;
		item.key       = key_val;
		item.new_value = repl;
		@(negedge clk);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsp.push_back(ring_apply(item));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// long bursts now and then, short ones otherwise
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(0, 12);
			gap = $urandom_range(1, 10);
			@(negedge clk);
			req_valid <= 1'b0;
			// payload is free to wander while valid is low
			req.key <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender stops until every owed result has come back
	task automatic pause_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// key choice: often values already queued so that scans hit, plus repeats,
	// extremes and fully random words
	function automatic logic signed [31:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4 && ring_count > 0)
			return ring_store[(ring_head + $urandom_range(0, ring_count - 1)) % QDEPTH];
		if (roll < 7)
			return $signed($urandom_range(0, 15)) - 8;
		if (roll == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7fff_ffff;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom;
	endfunction

	// dequeue, search and update while nothing is queued
	task automatic test_empty_queue();
		send_request(fqks_pkg::ACT_DEQUEUE, 32'sd0, 32'sd0);
		send_request(fqks_pkg::ACT_SEARCH, 32'sd0, 32'sd0);
		send_request(fqks_pkg::ACT_UPDATE, 32'sh8000_0000, 32'sh8000_0000);
	endtask

	// extreme keys, a hit deep in the queue, misses, and update returning the old value
	task automatic test_extreme_keys();
		send_request(fqks_pkg::ACT_ENQUEUE, 32'sh8000_0000, 32'sd0);
		send_request(fqks_pkg::ACT_ENQUEUE, 32'sh7fff_ffff, 32'sd0);
		send_request(fqks_pkg::ACT_ENQUEUE, 32'sd0, 32'sd0);
		send_request(fqks_pkg::ACT_ENQUEUE, -32'sd1, 32'sd0);
		send_request(fqks_pkg::ACT_SEARCH, -32'sd1, 32'sd0);
		send_request(fqks_pkg::ACT_SEARCH, 32'sd12345, 32'sd0);
		send_request(fqks_pkg::ACT_UPDATE, 32'sh8000_0000, 32'sh7fff_ffff);
		send_request(fqks_pkg::ACT_UPDATE, 32'sd777, -32'sd1);
		// front now holds the updated value
		send_request(fqks_pkg::ACT_DEQUEUE, 32'sd0, 32'sd0);
	endtask

	// fill to the brim, get refused once, then scan all the way to the rear
	task automatic test_fill_to_full();
		int unsigned i;
		for (i = 0; i < 13; i++)
			send_request(fqks_pkg::ACT_ENQUEUE, 32'sd1 <<< (2 * i + 4), 32'sd0);
		send_request(fqks_pkg::ACT_ENQUEUE, 32'sh5a5a_5a5a, 32'sd0);
		send_request(fqks_pkg::ACT_SEARCH, 32'sd1 <<< 28, 32'sd0);
	endtask

	// random traffic; a tide that flips now and then moves the enqueue share between high and low
	task automatic test_random_traffic(input int n_items);
		int                 n;
		int                 tide_left;
		int unsigned        enq_pct;
		int unsigned        roll;
		logic               filling;
		fqks_pkg::action_t  act;
		logic signed [31:0] repl;
		tide_left = 0;
		filling = 1'b1;
		for (n = 0; n < n_items; n++) begin
			if (tide_left == 0) begin
				filling = ~filling;
				tide_left = $urandom_range(20, 60);
			end
			tide_left--;
			enq_pct = filling ? 60 : 25;
			roll = $urandom_range(0, 99);
			if (roll < enq_pct)
				act = fqks_pkg::ACT_ENQUEUE;
			else if (roll < enq_pct + 20)
				act = fqks_pkg::ACT_DEQUEUE;
			else if (roll[0])
				act = fqks_pkg::ACT_UPDATE;
			else
				act = fqks_pkg::ACT_SEARCH;
			repl = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 15)) - 8;
			send_request(act, pick_key(), repl);
		end
	endtask

	// receiver holds off long enough that the block stalls its input
	task automatic test_backpressure();
		hold_off_cycles = 150;
		test_random_traffic(40);
	endtask

	// receiver: stall pattern of its own, or a counted hold-off when one is asked for
	initial begin : rsp_stall_driver
		int          stretch_left;
		stall_mode_t mode;
		rsp_stall = 1'b0;
		stretch_left = 0;
		mode = STALL_NONE;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_off_cycles--;
			end else begin
				if (stretch_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(20, 120);
				end
				stretch_left--;
				case (mode)
					STALL_NONE:  rsp_stall <= 1'b0;
					STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
					default:     rsp_stall <= (stretch_left % 3 == 0);
				endcase
			end
		end
	end

	// result check: every transfer against the oldest owed result
	always @(posedge clk) begin : result_check
		fqks_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("%0t: result with none owed: status %0d value %h count %0d",
						$time, rsp.status, rsp.value_out, rsp.entry_count);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.value_out !== want.value_out
						|| rsp.entry_count !== want.entry_count) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: mismatch got/want: status %0d/%0d value %h/%h count %0d/%0d",
							$time, rsp.status, want.status, rsp.value_out,
							want.value_out, rsp.entry_count, want.entry_count);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		n_errors = 0;
		burst_left = 0;
		hold_off_cycles = 0;
		ring_head = 0;
		ring_tail = 0;
		ring_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_extreme_keys();
		test_fill_to_full();
		pause_until_drained();
		test_random_traffic(550);
		test_backpressure();
		pause_until_drained();
		test_random_traffic(600);

		// all requests are in; let the last results come out, then watch for strays
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_errors == 0)
			$display("tb_fifo_queue_with_key_search: done, clean");
		else
			$display("tb_fifo_queue_with_key_search: done, errors");
		$finish;
	end

endmodule

// ===== fifo_queue_with_key_search.f =====
+incdir+design
design/fqks_pkg.sv
design/fqks_ctrl.sv
design/fqks_dp.sv
design/fifo_queue_with_key_search.sv
verif/tb_fifo_queue_with_key_search.sv
